// ===== sv/bpfa_pkg.sv =====
// Shared types and constants for the bitmap page frame allocator.
// Operation and status codes, controller states, register indexes.
// No dependencies.
package bpfa_pkg;

  localparam int ADDR_W    = 48;
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int NBITS_W   = 7;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOMEM  = 3'd1,
    ST_RANGE  = 3'd2,
    ST_ALIGN  = 3'd3,
    ST_DOUBLE = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_CNT,
    S_INIT_MAP,
    S_INIT_CLR,
    S_ALLOC_SCAN,
    S_ALLOC_ADDR,
    S_FREE_OFS,
    S_FREE_CHK,
    S_FREE_UPD,
    S_DONE
  } fsm_t;

  localparam logic REG_BASE_ADDR = 1'b0;
  localparam logic REG_MEM_END   = 1'b1;

endpackage

// ===== sv/bpfa_word_scan.sv =====
// First-fit search over one 64-bit bitmap word.
// Finds the lowest clear bit below a valid-bit count. Uses bpfa_pkg widths.
module bpfa_word_scan (
  input  logic [bpfa_pkg::WORD_BITS-1:0] word,
  input  logic [bpfa_pkg::NBITS_W-1:0]   nbits,
  output logic                           hit,
  output logic [bpfa_pkg::BIT_W-1:0]     bit_idx
);
  import bpfa_pkg::*;

  // scan from the top so the lowest free bit wins
  always_comb begin
    hit     = 1'b0;
    bit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i] && (NBITS_W'(i) < nbits)) begin
        hit     = 1'b1;
        bit_idx = BIT_W'(i);
      end
    end
  end

endmodule

// ===== sv/bitmap_page_frame_allocator_core.sv =====
// Bitmap page frame allocator, first fit, top level.
// Holds the used-frame bitmap memory and the controller; uses bpfa_pkg and
// bpfa_word_scan.
//
// Usage:
//   Request channel (req_valid/req_ready) carries operation and frame_address.
//   Response channel (rsp_valid/rsp_ready) carries result_address and status,
//   exactly one response transaction per request transaction, in order.
//   cfg_we/cfg_index/cfg_data write the region base (index 0) or mem_end
//   (index 1); write them only while no request is outstanding, then issue an init.
//
// Sequence (steps from the accepting edge to the edge that raises rsp_valid):
//   free  : offset subtract, range/alignment check with bitmap read,
//           read-modify-write of one word, response load.
//   alloc : one word read per cycle out of the synchronous bitmap memory,
//           from word 0 up to a hit or the last used word, then address
//           and response load; no scan when no frames are managed.
//   init  : the bitmap is rewritten one word per cycle.
//   One request is in flight at a time; req_ready is high only when idle.
//   The response sits in an output register, so a new request may be taken
//   while the previous response still waits. A stalled receiver holds the
//   block in its final step until the output register frees up.
//
// Reset: page_count, the region base and mem_end clear. The bitmap memory is
//   not cleared; with zero managed frames its contents are never used, and
//   init rewrites it.
// PAGE_BYTES must be a power of two.
module bitmap_page_frame_allocator_core #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bpfa_pkg::ADDR_W-1:0]   cfg_data,
  // request channel
  input  logic                          req_valid,
  output logic                          req_ready,
  input  bpfa_pkg::op_t                 operation,
  input  logic [bpfa_pkg::ADDR_W-1:0]   frame_address,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [bpfa_pkg::ADDR_W-1:0]   result_address,
  output bpfa_pkg::status_t             status
);
  import bpfa_pkg::*;

  localparam int WORDS     = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PG_W      = WA_W + BIT_W;
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);
  localparam int SHIFT     = $clog2(PAGE_BYTES);
  localparam int MAP_SHIFT = SHIFT + 3;
  localparam int Q_W       = ADDR_W - SHIFT;
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  fsm_t              state, state_next;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] mem_end;
  logic [CNT_W-1:0]  page_count;
  logic              data_vld;

  // Datapath registers
  logic [ADDR_W-1:0]    cur_addr;
  logic [ADDR_W:0]      ofs;
  logic [ADDR_W-1:0]    pend_res;
  status_t              pend_st;
  logic [WA_W-1:0]      rd_ptr;
  logic [WA_W-1:0]      data_ptr;
  logic [WA_W-1:0]      clr_ptr;
  logic [WA_W-1:0]      last_word;
  logic [WORD_BITS-1:0] init_mask;
  logic [PG_W-1:0]      hit_page;
  logic [PG_W-1:0]      free_page;

  // Bitmap memory
  logic [WORD_BITS-1:0] bitmap [WORDS];
  logic                 mem_we;
  logic [WA_W-1:0]      mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic [WA_W-1:0]      mem_ra;
  logic [WORD_BITS-1:0] mem_rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[mem_wa] <= mem_wd;
    end
    mem_rd <= bitmap[mem_ra];
  end

  // ---------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------
  logic              accept;
  logic              out_free;
  logic [ADDR_W:0]   init_diff;
  logic [Q_W-1:0]    init_q;
  logic [CNT_W-1:0]  init_count;
  logic [31:0]       map_sum;
  logic [31:0]       map_pages;
  logic [NBITS_W-1:0] map_marks;
  logic [WORD_BITS-1:0] map_mask;
  logic [CNT_W-1:0]  count_m1;
  logic [BIT_W-1:0]  tail;
  logic [NBITS_W-1:0] scan_nbits;
  logic              scan_hit;
  logic [BIT_W-1:0]  scan_bit;
  logic              range_bad;
  logic              align_bad;
  logic [PG_W-1:0]   chk_page;
  logic [ADDR_W-1:0] page_ofs;
  logic              free_bit_set;

  assign accept   = req_valid && req_ready;
  assign out_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // frame count from the configured window, zero if inverted, saturated
  always_comb begin
    init_diff = {1'b0, mem_end} - {1'b0, base_addr};
    init_q    = init_diff[ADDR_W-1:SHIFT];
    if (init_diff[ADDR_W]) begin
      init_count = '0;
    end else if (init_q > Q_W'(MAX_PAGES)) begin
      init_count = CNT_W'(MAX_PAGES);
    end else begin
      init_count = CNT_W'(init_q);
    end
  end

  // frames taken by the bitmap itself: ceil(count / (8 * PAGE_BYTES)).
  // With the default parameters that is at most 1, so it fits word 0.
  always_comb begin
    map_sum   = 32'(page_count) + 32'(8 * PAGE_BYTES - 1);
    map_pages = map_sum >> MAP_SHIFT;
    if (map_pages < 32'(page_count)) begin
      map_marks = NBITS_W'(map_pages);
    end else begin
      map_marks = NBITS_W'(page_count);
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      map_mask[i] = (NBITS_W'(i) < map_marks);
    end
  end

  assign count_m1 = page_count - CNT_W'(1);
  assign tail     = page_count[BIT_W-1:0];

  // only the last used word has a partial set of managed frames
  assign scan_nbits = ((data_ptr == last_word) && (tail != '0)) ?
                      {1'b0, tail} : NBITS_W'(WORD_BITS);

  bpfa_word_scan u_scan (
    .word    (mem_rd),
    .nbits   (scan_nbits),
    .hit     (scan_hit),
    .bit_idx (scan_bit)
  );

  // range is checked on the offset from the region base in whole pages
  assign range_bad = ofs[ADDR_W] || (ofs[ADDR_W-1:SHIFT] >= Q_W'(page_count));
  assign align_bad = (cur_addr[SHIFT-1:0] != '0);
  assign chk_page  = ofs[SHIFT +: PG_W];
  assign free_bit_set = mem_rd[free_page[BIT_W-1:0]];
  assign page_ofs  = ADDR_W'(hit_page) << SHIFT;

  // ---------------------------------------------------------------------
  // Next state and memory control
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    mem_ra     = rd_ptr;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (operation)
            OP_ALLOC: state_next = (page_count == '0) ? S_DONE : S_ALLOC_SCAN;
            OP_FREE:  state_next = S_FREE_OFS;
            OP_INIT:  state_next = S_INIT_CNT;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_INIT_CNT: state_next = S_INIT_MAP;
      S_INIT_MAP: state_next = S_INIT_CLR;
      S_INIT_CLR: begin
        // sweep: clear every word, word 0 gets the bitmap's own frames
        mem_we = 1'b1;
        mem_wa = clr_ptr;
        mem_wd = (clr_ptr == '0) ? init_mask : '0;
        if (clr_ptr == LAST_WORD) begin
          state_next = S_DONE;
        end
      end
      S_ALLOC_SCAN: begin
        mem_ra = rd_ptr;
        if (data_vld) begin
          if (scan_hit) begin
            mem_we     = 1'b1;
            mem_wa     = data_ptr;
            mem_wd     = mem_rd | (WORD_BITS'(1) << scan_bit);
            state_next = S_ALLOC_ADDR;
          end else if (data_ptr == last_word) begin
            state_next = S_DONE;
          end
        end
      end
      S_ALLOC_ADDR: state_next = S_DONE;
      S_FREE_OFS:   state_next = S_FREE_CHK;
      S_FREE_CHK: begin
        mem_ra     = chk_page[PG_W-1:BIT_W];
        state_next = (range_bad || align_bad) ? S_DONE : S_FREE_UPD;
      end
      S_FREE_UPD: begin
        if (free_bit_set) begin
          mem_we = 1'b1;
          mem_wa = free_page[PG_W-1:BIT_W];
          mem_wd = mem_rd & ~(WORD_BITS'(1) << free_page[BIT_W-1:0]);
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers with reset
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      base_addr  <= '0;
      mem_end    <= '0;
      page_count <= '0;
      data_vld   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_ADDR: base_addr <= cfg_data;
          REG_MEM_END:   mem_end   <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_INIT_CNT) begin
        page_count <= init_count;
      end
      // read data is registered, so it arrives the cycle after its read address
      if (accept) begin
        data_vld <= 1'b0;
      end else if (state == S_ALLOC_SCAN) begin
        data_vld <= 1'b1;
      end
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cur_addr <= frame_address;
          pend_res <= '0;
          pend_st  <= (operation == OP_ALLOC) ? ST_NOMEM : ST_OK;
          rd_ptr   <= '0;
          clr_ptr  <= '0;
        end
      end
      S_INIT_MAP: begin
        init_mask <= map_mask;
        last_word <= WA_W'(count_m1 >> BIT_W);
      end
      S_INIT_CLR: begin
        clr_ptr <= clr_ptr + WA_W'(1);
      end
      S_ALLOC_SCAN: begin
        // hold the pointer at the last used word
        if (rd_ptr != last_word) begin
          rd_ptr <= rd_ptr + WA_W'(1);
        end
        data_ptr <= rd_ptr;
        if (data_vld && scan_hit) begin
          hit_page <= {data_ptr, scan_bit};
        end
      end
      S_ALLOC_ADDR: begin
        pend_res <= base_addr + page_ofs;
        pend_st  <= ST_OK;
      end
      S_FREE_OFS: begin
        ofs <= {1'b0, cur_addr} - {1'b0, base_addr};
      end
      S_FREE_CHK: begin
        free_page <= chk_page;
        if (range_bad) begin
          pend_st <= ST_RANGE;
        end else if (align_bad) begin
          pend_st <= ST_ALIGN;
        end
      end
      S_FREE_UPD: begin
        if (!free_bit_set) begin
          pend_st <= ST_DOUBLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          result_address <= pend_res;
          status         <= pend_st;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    page_count <= CNT_W'(MAX_PAGES))
    else $error("page count above MAX_PAGES");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req_ready)
    else $error("second request taken while one is in flight");

  a_err_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_OK) |-> (result_address == '0))
    else $error("error response carries a nonzero address");

  a_alloc_one_bit: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == S_ALLOC_SCAN) |->
      ($countones(mem_wd) == $countones(mem_rd) + 1))
    else $error("allocation write-back did not set exactly one bit");

endmodule
